/* rtl/bba_pkg.sv */
// Package for the 8-bit binary/BCD ALU: command codes and the request and
// response structs passed between the core and the top level. No dependencies.
package bba_pkg;

  typedef enum logic [2:0] {
    CmdAddBin = 3'd0,
    CmdAddBcd = 3'd1,
    CmdSubBin = 3'd2,
    CmdSubBcd = 3'd3,
    CmdShr    = 3'd4,
    CmdRol    = 3'd5,
    CmdRor    = 3'd6
  } cmd_e;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DigitW = 4;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [ByteW-1:0] lhs;
    logic [ByteW-1:0] rhs;
    logic             carry_in;
  } alu_req_t;

  typedef struct packed {
    logic [ByteW-1:0] result;
    logic             carry_out;
    logic             sign_changed;
  } alu_rsp_t;

  // Commands that set the sign-change flag.
  function automatic logic is_arith(logic [CmdW-1:0] cmd);
    return (cmd == CmdAddBin) || (cmd == CmdAddBcd) ||
           (cmd == CmdSubBin) || (cmd == CmdSubBcd);
  endfunction

endpackage

/* rtl/bba_digit.sv */
// One packed-BCD digit adder/subtractor with carry or borrow in and out.
// Depends on bba_pkg for the digit width.
module bba_digit (
  input  logic [bba_pkg::DigitW-1:0] a_i,
  input  logic [bba_pkg::DigitW-1:0] b_i,
  input  logic                       sub_i,   // 1: subtract, ci/co are borrows
  input  logic                       ci_i,
  output logic [bba_pkg::DigitW-1:0] digit_o,
  output logic                       co_o
);

  logic [5:0] sum;   // a + b + c, 0..31
  logic [5:0] diff;  // a - b - borrow + 20, 4..35
  logic [5:0] pre;

  always_comb begin
    sum  = 6'(a_i) + 6'(b_i) + 6'(ci_i);
    diff = 6'd20 + 6'(a_i) - 6'(b_i) - 6'(ci_i);
    if (sub_i) begin
      co_o = (diff < 6'd20);
      pre  = diff;
    end else begin
      co_o = (sum > 6'd9);
      pre  = sum;
    end
    // reduce mod 10; value stays below 40
    if (pre >= 6'd30) begin
      digit_o = 4'(pre - 6'd30);
    end else if (pre >= 6'd20) begin
      digit_o = 4'(pre - 6'd20);
    end else if (pre >= 6'd10) begin
      digit_o = 4'(pre - 6'd10);
    end else begin
      digit_o = pre[3:0];
    end
  end

endmodule

/* rtl/bba_core.sv */
// Combinational ALU datapath: binary add/subtract, BCD add/subtract via two
// digit cells, shift and rotates. Depends on bba_pkg and bba_digit.
module bba_core (
  input  bba_pkg::alu_req_t req_i,
  output bba_pkg::alu_rsp_t rsp_o
);

  logic [bba_pkg::DigitW-1:0] lo_digit, hi_digit;
  logic                       lo_co, hi_co;
  logic                       dec_sub;
  logic                       dec_ci;
  logic [bba_pkg::ByteW:0]    bin_add, bin_sub;
  logic [bba_pkg::ByteW-1:0]  res;
  logic                       cout;

  assign dec_sub = (req_i.command == bba_pkg::CmdSubBcd);
  // borrow chain starts at the inverted carry for subtract
  assign dec_ci  = dec_sub ? ~req_i.carry_in : req_i.carry_in;

  bba_digit u_lo (
    .a_i    (req_i.lhs[3:0]),
    .b_i    (req_i.rhs[3:0]),
    .sub_i  (dec_sub),
    .ci_i   (dec_ci),
    .digit_o(lo_digit),
    .co_o   (lo_co)
  );

  bba_digit u_hi (
    .a_i    (req_i.lhs[7:4]),
    .b_i    (req_i.rhs[7:4]),
    .sub_i  (dec_sub),
    .ci_i   (lo_co),
    .digit_o(hi_digit),
    .co_o   (hi_co)
  );

  always_comb begin
    bin_add = 9'(req_i.lhs) + 9'(req_i.rhs) + 9'(req_i.carry_in);
    // invert rhs at byte width, then zero-extend
    bin_sub = 9'(req_i.lhs) + {1'b0, ~req_i.rhs} + 9'(req_i.carry_in);
    res     = req_i.lhs;
    cout    = req_i.carry_in;
    case (req_i.command)
      bba_pkg::CmdAddBin: begin
        res  = bin_add[7:0];
        cout = bin_add[8];
      end
      bba_pkg::CmdAddBcd: begin
        res  = {hi_digit, lo_digit};
        cout = hi_co;
      end
      bba_pkg::CmdSubBin: begin
        res  = bin_sub[7:0];
        cout = bin_sub[8];
      end
      bba_pkg::CmdSubBcd: begin
        res  = {hi_digit, lo_digit};
        cout = ~hi_co;
      end
      bba_pkg::CmdShr: begin
        res  = {1'b0, req_i.lhs[7:1]};
        cout = req_i.lhs[0];
      end
      bba_pkg::CmdRol: begin
        res  = {req_i.lhs[6:0], req_i.carry_in};
        cout = req_i.lhs[7];
      end
      bba_pkg::CmdRor: begin
        res  = {req_i.carry_in, req_i.lhs[7:1]};
        cout = req_i.lhs[0];
      end
      default: begin
        res  = req_i.lhs;
        cout = req_i.carry_in;
      end
    endcase
    rsp_o.result       = res;
    rsp_o.carry_out    = cout;
    rsp_o.sign_changed = bba_pkg::is_arith(req_i.command) & (res[7] ^ req_i.lhs[7]);
  end

endmodule

/* rtl/bcd_binary_alu_8bit.sv */
// Pipeline: input register, then result register, with the single-pass
//   datapath between the two registers; one transfer per cycle while
//   m_axis_tready does not stall the result stream.
// Reset (rst_ni low, asynchronous): both stages empty, s_axis_tready high.
// Top level of the 8-bit binary/BCD ALU; depends on bba_pkg and bba_core.
module bcd_binary_alu_8bit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [2:0] command, [10:3] lhs, [18:11] rhs,
                                      // [19] carry_in, [23:20] zero
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] result, [8] carry_out,
                                      // [9] sign_changed, [15:10] zero
);

  // Input stage
  logic              s1_valid_q, s1_valid_d;
  bba_pkg::alu_req_t s1_req_q;
  logic              s1_adv;      // stage 1 may hand its item on
  logic              s_fire;

  // Result stage
  logic              m_valid_q, m_valid_d;
  bba_pkg::alu_rsp_t m_rsp_q;
  bba_pkg::alu_rsp_t core_rsp;

  // Advance the input stage when the result register is empty or drains now.
  assign s1_adv        = ~m_valid_q | m_axis_tready;
  assign s_axis_tready = ~s1_valid_q | s1_adv;
  assign s_fire        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s_axis_tready) begin
      s1_valid_d = s_axis_tvalid;
    end
    m_valid_d = m_valid_q;
    if (s1_adv) begin
      m_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // Capture the request on every input transfer.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_req_q.command  <= s_axis_tdata[2:0];
      s1_req_q.lhs      <= s_axis_tdata[10:3];
      s1_req_q.rhs      <= s_axis_tdata[18:11];
      s1_req_q.carry_in <= s_axis_tdata[19];
    end
  end

  bba_core u_core (
    .req_i(s1_req_q),
    .rsp_o(core_rsp)
  );

  // Load the result register when stage 1 holds an item and may advance.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      m_rsp_q <= core_rsp;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, m_rsp_q.sign_changed, m_rsp_q.carry_out, m_rsp_q.result};

  // Checks

  logic s1_move;
  logic s1_logic_cmd;
  logic s1_bcd_cmd;

  assign s1_move      = s1_valid_q & s1_adv;
  assign s1_logic_cmd = (s1_req_q.command == bba_pkg::CmdShr) ||
                        (s1_req_q.command == bba_pkg::CmdRol) ||
                        (s1_req_q.command == bba_pkg::CmdRor);
  assign s1_bcd_cmd   = (s1_req_q.command == bba_pkg::CmdAddBcd) ||
                        (s1_req_q.command == bba_pkg::CmdSubBcd);

  // Input backpressure only when both stages are full and the output stalls.
  a_tready_low_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid_q && m_valid_q && !m_axis_tready))
    else $error("input stalled while a stage is free");

  // Shift and rotate never raise the sign-change flag.
  a_logic_no_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && s1_logic_cmd) |=> (m_axis_tvalid && !m_axis_tdata[9]))
    else $error("sign_changed set for shift or rotate");

  // Decimal commands yield two digits in range.
  a_bcd_digits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && s1_bcd_cmd) |=>
      (m_axis_tdata[3:0] <= 4'd9) && (m_axis_tdata[7:4] <= 4'd9))
    else $error("decimal result digit out of range");

endmodule

/* bench/bcd_alu_checker.sv */
// Result checker for the 8-bit binary/BCD ALU: watches both stream channels,
// predicts each result and compares it field by field. Depends on bba_pkg.
`timescale 1ns / 1ps

module bcd_alu_checker
  import bba_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [23:0] in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] out_data_i,
  output int          error_count_o,
  output int          outstanding_o
);

  alu_rsp_t pending_results[$];
  int       mismatch_count = 0;

  initial begin
    error_count_o = 0;
    outstanding_o = 0;
  end

  // One packed BCD digit add: returns {carry, digit}.
  function automatic logic [4:0] bcd_digit_sum(logic [3:0] a, logic [3:0] b, logic cin);
    int s;
    s = int'(a) + int'(b) + int'(cin);
    return {s > 9, 4'(s % 10)};
  endfunction

  // One packed BCD digit subtract: returns {borrow, digit}.
  function automatic logic [4:0] bcd_digit_diff(logic [3:0] a, logic [3:0] b, logic bw);
    int d;
    d = int'(a) - int'(b) - int'(bw);
    return {d < 0, 4'((d + 20) % 10)};
  endfunction

  function automatic alu_rsp_t alu_compute(logic [2:0] command, logic [7:0] lhs,
                                           logic [7:0] rhs, logic carry_in);
    alu_rsp_t   rsp;
    logic [8:0] wide;
    logic [8:0] subtrahend;
    logic [4:0] lo_digit;
    logic [4:0] hi_digit;
    logic       arith;
    rsp.result    = lhs;
    rsp.carry_out = carry_in;
    arith         = 1'b0;
    case (command)
      CmdAddBin: begin
        wide = {1'b0, lhs} + {1'b0, rhs} + {8'd0, carry_in};
        rsp.result    = wide[7:0];
        rsp.carry_out = wide[8];
        arith         = 1'b1;
      end
      CmdAddBcd: begin
        lo_digit = bcd_digit_sum(lhs[3:0], rhs[3:0], carry_in);
        hi_digit = bcd_digit_sum(lhs[7:4], rhs[7:4], lo_digit[4]);
        rsp.result    = {hi_digit[3:0], lo_digit[3:0]};
        rsp.carry_out = hi_digit[4];
        arith         = 1'b1;
      end
      CmdSubBin: begin
        subtrahend    = {1'b0, rhs} + {8'd0, ~carry_in};
        wide          = {1'b0, lhs} - subtrahend;
        rsp.result    = wide[7:0];
        rsp.carry_out = ({1'b0, lhs} >= subtrahend);
        arith         = 1'b1;
      end
      CmdSubBcd: begin
        lo_digit = bcd_digit_diff(lhs[3:0], rhs[3:0], ~carry_in);
        hi_digit = bcd_digit_diff(lhs[7:4], rhs[7:4], lo_digit[4]);
        rsp.result    = {hi_digit[3:0], lo_digit[3:0]};
        rsp.carry_out = ~hi_digit[4];
        arith         = 1'b1;
      end
      CmdShr: begin
        rsp.result    = {1'b0, lhs[7:1]};
        rsp.carry_out = lhs[0];
      end
      CmdRol: begin
        rsp.result    = {lhs[6:0], carry_in};
        rsp.carry_out = lhs[7];
      end
      CmdRor: begin
        rsp.result    = {carry_in, lhs[7:1]};
        rsp.carry_out = lhs[0];
      end
      default: ;
    endcase
    rsp.sign_changed = arith & (rsp.result[7] ^ lhs[7]);
    return rsp;
  endfunction

  always @(posedge clk_i) begin
    alu_rsp_t want;
    alu_rsp_t got;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        // unpack in bus order: result low, then carry, then sign flag
        got.result       = out_data_i[7:0];
        got.carry_out    = out_data_i[8];
        got.sign_changed = out_data_i[9];
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR %0t: result transfer with nothing expected, data %h",
                     $realtime, out_data_i);
        end else begin
          want = pending_results.pop_front();
          if (got.result !== want.result || got.carry_out !== want.carry_out ||
              got.sign_changed !== want.sign_changed) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("ERROR %0t: expected result %h carry %b sign %b, got %h %b %b",
                       $realtime, want.result, want.carry_out, want.sign_changed,
                       got.result, got.carry_out, got.sign_changed);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        pending_results.push_back(alu_compute(in_data_i[2:0], in_data_i[10:3],
                                              in_data_i[18:11], in_data_i[19]));
    end
    error_count_o <= mismatch_count;
    outstanding_o <= pending_results.size();
  end

endmodule

/* bench/bcd_binary_alu_8bit_tb.sv */
// Testbench top for bcd_binary_alu_8bit: drives directed and random ALU
// operations, randomizes both handshakes and reports the verdict.
// Depends on bba_pkg, bcd_binary_alu_8bit and bcd_alu_checker.
`timescale 1ns / 1ps

module bcd_binary_alu_8bit_tb;
  import bba_pkg::*;

  // Command code the block does not define; it must pass lhs and carry through.
  localparam logic [2:0] CmdUnused  = 3'd7;
  localparam int         CycleLimit = 200000;
  localparam int         RandomOps  = 1100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [2:0] command, [10:3] lhs, [18:11] rhs,
                                    // [19] carry_in, [23:20] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [7:0] result, [8] carry_out,
                                    // [9] sign_changed, [15:10] zero

  int error_count;
  int outstanding;
  int cycle_count = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int hold_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  bcd_binary_alu_8bit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  bcd_alu_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .error_count_o(error_count),
    .outstanding_o(outstanding)
  );

  // Bail out if the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("bcd_binary_alu_8bit: mismatch");
      $finish;
    end
  end

  // Result side: a requested hold-off wins, otherwise stall at random.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Offer one operation; idle first at random, then hold it until the transfer.
  // Returns at the accepting edge, so the next call starts on the next falling edge.
  task automatic send_op(logic [2:0] command, logic [7:0] lhs, logic [7:0] rhs,
                         logic carry_in);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, carry_in, rhs, lhs, command};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Mostly valid packed BCD, now and then any byte to cover the odd digits.
  function automatic logic [7:0] pick_operand(logic [2:0] command);
    if ((command == CmdAddBcd || command == CmdSubBcd) && $urandom_range(99) < 80)
      return {4'($urandom_range(9)), 4'($urandom_range(9))};
    return 8'($urandom_range(255));
  endfunction

  task automatic send_random_ops(int count);
    logic [2:0] command;
    for (int i = 0; i < count; i++) begin
      command = ($urandom_range(99) < 4) ? CmdUnused : 3'($urandom_range(6));
      send_op(command, pick_operand(command), pick_operand(command),
              1'($urandom_range(1)));
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Phase one: light sender gaps, heavy receiver stalls.
    src_idle_pct  = 19;
    sink_idle_pct = 53;

    // Binary add: carry out, sign flip, carry in alone, all ones.
    send_op(CmdAddBin, 8'hff, 8'h01, 1'b0);
    send_op(CmdAddBin, 8'h7f, 8'h01, 1'b0);
    send_op(CmdAddBin, 8'h00, 8'h00, 1'b1);
    send_op(CmdAddBin, 8'hff, 8'hff, 1'b1);
    // Decimal add: wrap to 00, digit carries, non-BCD nibbles.
    send_op(CmdAddBcd, 8'h99, 8'h01, 1'b0);
    send_op(CmdAddBcd, 8'h45, 8'h55, 1'b1);
    send_op(CmdAddBcd, 8'h09, 8'h01, 1'b0);
    send_op(CmdAddBcd, 8'hff, 8'hff, 1'b1);
    // Binary subtract: underflow, sign flip, borrow in, no-op.
    send_op(CmdSubBin, 8'h00, 8'h01, 1'b1);
    send_op(CmdSubBin, 8'h80, 8'h01, 1'b1);
    send_op(CmdSubBin, 8'h05, 8'h05, 1'b0);
    send_op(CmdSubBin, 8'hff, 8'h00, 1'b1);
    // Decimal subtract: underflow, digit borrow, borrow in, non-BCD nibbles.
    send_op(CmdSubBcd, 8'h00, 8'h01, 1'b1);
    send_op(CmdSubBcd, 8'h10, 8'h01, 1'b1);
    send_op(CmdSubBcd, 8'h99, 8'h99, 1'b0);
    send_op(CmdSubBcd, 8'h0f, 8'hf0, 1'b0);
    // Shift and rotates at both ends of the byte.
    send_op(CmdShr, 8'h01, 8'h00, 1'b1);
    send_op(CmdShr, 8'hff, 8'hff, 1'b0);
    send_op(CmdRol, 8'h80, 8'h00, 1'b0);
    send_op(CmdRol, 8'h7f, 8'hff, 1'b1);
    send_op(CmdRor, 8'h01, 8'h00, 1'b1);
    send_op(CmdRor, 8'hfe, 8'hff, 1'b0);
    // Undefined command passes operand and carry through.
    send_op(CmdUnused, 8'ha5, 8'h5a, 1'b1);
    send_op(CmdUnused, 8'h5a, 8'ha5, 1'b0);

    send_random_ops(RandomOps / 3);

    // Phase two: the other way round.
    src_idle_pct  = 53;
    sink_idle_pct = 19;
    send_random_ops(RandomOps / 3);

    // Phase three: full rate. Stall the receiver long enough for the pipe to
    // fill and push back on the input, then let everything drain before going on.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_cycles   = 80;
    send_random_ops(40);
    drain_results();
    send_random_ops(RandomOps - 2 * (RandomOps / 3) - 40);

    drain_results();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("bcd_binary_alu_8bit: match");
    end else begin
      $display("bcd_binary_alu_8bit: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/bba_pkg.sv
rtl/bba_digit.sv
rtl/bba_core.sv
rtl/bcd_binary_alu_8bit.sv
bench/bcd_alu_checker.sv
bench/bcd_binary_alu_8bit_tb.sv
